// File: design/elt_pkg.sv
// Shared types, token codes and character constants for the tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package elt_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = 2;
	localparam int SLOTS = 3;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_NUM   = 2'd1,
		MODE_IDENT = 2'd2
	} run_mode_t;

	localparam logic [4:0] KIND_END     = 5'd0;
	localparam logic [4:0] KIND_NUMBER  = 5'd1;
	localparam logic [4:0] KIND_IDENT   = 5'd2;
	localparam logic [4:0] KIND_VAR     = 5'd3;
	localparam logic [4:0] KIND_RETURN  = 5'd4;
	localparam logic [4:0] KIND_FUN     = 5'd5;
	localparam logic [4:0] KIND_PLUS    = 5'd6;
	localparam logic [4:0] KIND_MINUS   = 5'd7;
	localparam logic [4:0] KIND_STAR    = 5'd8;
	localparam logic [4:0] KIND_SLASH   = 5'd9;
	localparam logic [4:0] KIND_CARET   = 5'd10;
	localparam logic [4:0] KIND_LPAREN  = 5'd11;
	localparam logic [4:0] KIND_RPAREN  = 5'd12;
	localparam logic [4:0] KIND_LBRACE  = 5'd13;
	localparam logic [4:0] KIND_RBRACE  = 5'd14;
	localparam logic [4:0] KIND_ASSIGN  = 5'd15;
	localparam logic [4:0] KIND_COMMA   = 5'd16;
	localparam logic [4:0] KIND_SEMI    = 5'd17;
	localparam logic [4:0] KIND_UNKNOWN = 5'd18;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_ASSIGN  = 8'h3D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_SEMI    = 8'h3B;

	localparam logic [47:0] KW_VAR    = 48'h0000_0076_6172;
	localparam logic [47:0] KW_FUN    = 48'h0000_0066_756E;
	localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
	} token_t;

	typedef struct packed {
		logic [1:0]             cnt;
		token_t [SLOTS-1:0]     tok;
	} entry_t;

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_SLASH:  k = KIND_SLASH;
			CH_CARET:  k = KIND_CARET;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_ASSIGN: k = KIND_ASSIGN;
			CH_COMMA:  k = KIND_COMMA;
			CH_SEMI:   k = KIND_SEMI;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: design/expression_language_tokenizer_core.sv
// Top level of the streaming expression tokenizer.
// Data path: an accepted byte's token group is queued, then each token is registered for output.
// Throughput: one byte per cycle while the queue is not full and each byte yields at most one token;
// tokens leave one per cycle from the output register while pop is held, so a byte yielding two or
// three tokens takes one output slot per token, with a four-word group queue absorbing bursts.
// Reset: arst_n clears run state, offset, queue and output valid flag; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module expression_language_tokenizer_core #(
	parameter int POS_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  source_byte,
	input  wire logic        final_byte,
	input  wire logic        push,
	output logic             full,
	output logic [4:0]       token_kind,
	output logic [15:0]      start_offset,
	output logic [15:0]      token_length,
	output logic             run_last,
	output logic             empty,
	input  wire logic        pop
);

	elt_pkg::entry_t front_entry, head;
	logic            front_push, q_full, q_empty, q_rd, accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	elt_front #(.POS_BITS(POS_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.source_byte (source_byte),
		.final_byte  (final_byte),
		.accept      (accept),
		.entry       (front_entry),
		.entry_push  (front_push)
	);

	elt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (front_push),
		.wr_data (front_entry),
		.q_full  (q_full),
		.rd      (q_rd),
		.rd_data (head),
		.q_empty (q_empty)
	);

	elt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.token_kind   (token_kind),
		.start_offset (start_offset),
		.token_length (token_length),
		.run_last     (run_last)
	);

endmodule

`default_nettype wire

// File: design/elt_front.sv
// Front end: run tracking and classification of each byte into a packed token group.
`timescale 1ns / 1ps
`default_nettype none

module elt_front #(
	parameter int POS_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     source_byte,
	input  wire logic           final_byte,
	input  wire logic           accept,
	output elt_pkg::entry_t     entry,
	output logic                entry_push
);

	elt_pkg::run_mode_t   mode_q, mode_n;
	logic [POS_BITS-1:0]  start_q, start_n;
	logic [POS_BITS-1:0]  pos_q, pos_inc;
	logic [15:0]          len_q, len_n;
	logic [47:0]          pre_q, pre_n;

	logic                 is_dig, is_let, is_ws, ext;
	logic [3:0]           cv;
	elt_pkg::token_t      cand [4];
	logic [1:0]           cnt;

	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic elt_pkg::token_t close_tok(input elt_pkg::run_mode_t m,
			input logic [POS_BITS-1:0] s, input logic [15:0] l, input logic [47:0] p);
		elt_pkg::token_t t;
		t.kind  = elt_pkg::KIND_NUMBER;
		if (m == elt_pkg::MODE_IDENT) begin
			if (l == 16'd3 && p == elt_pkg::KW_VAR)
				t.kind = elt_pkg::KIND_VAR;
			else if (l == 16'd6 && p == elt_pkg::KW_RETURN)
				t.kind = elt_pkg::KIND_RETURN;
			else if (l == 16'd3 && p == elt_pkg::KW_FUN)
				t.kind = elt_pkg::KIND_FUN;
			else
				t.kind = elt_pkg::KIND_IDENT;
		end
		t.start = sat16(s);
		t.len   = l;
		return t;
	endfunction

	assign is_dig = (source_byte >= 8'h30) && (source_byte <= 8'h39);
	assign is_let = ((source_byte >= 8'h61) && (source_byte <= 8'h7A)) ||
	                ((source_byte >= 8'h41) && (source_byte <= 8'h5A));
	assign is_ws  = (source_byte == elt_pkg::CH_SPACE) || (source_byte == elt_pkg::CH_NEWLINE);
	assign ext    = ((mode_q == elt_pkg::MODE_NUM) && is_dig) ||
	                ((mode_q == elt_pkg::MODE_IDENT) && (is_dig || is_let));
	assign pos_inc = (pos_q == {POS_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;

	always_comb begin
		mode_n  = mode_q;
		start_n = start_q;
		len_n   = len_q;
		pre_n   = pre_q;
		cv      = '0;
		for (int i = 0; i < 4; i++)
			cand[i] = '0;

		if (ext) begin
			if (len_q < 16'd6)
				pre_n = {pre_q[39:0], source_byte};
			if (len_q != elt_pkg::LEN_MAX)
				len_n = len_q + 16'd1;
		end else begin
			cv[0]   = (mode_q != elt_pkg::MODE_NONE);
			cand[0] = close_tok(mode_q, start_q, len_q, pre_q);
			if (is_dig || is_let) begin
				mode_n  = is_dig ? elt_pkg::MODE_NUM : elt_pkg::MODE_IDENT;
				start_n = pos_q;
				len_n   = 16'd1;
				pre_n   = {40'd0, source_byte};
			end else begin
				mode_n  = elt_pkg::MODE_NONE;
				start_n = '0;
				len_n   = '0;
				pre_n   = '0;
				if (!is_ws) begin
					cv[1]   = 1'b1;
					cand[1] = '{kind: elt_pkg::punct_kind(source_byte),
					            start: sat16(pos_q), len: 16'd1};
				end
			end
		end

		if (final_byte) begin
			cv[2]   = (mode_n != elt_pkg::MODE_NONE);
			cand[2] = close_tok(mode_n, start_n, len_n, pre_n);
			cv[3]   = 1'b1;
			cand[3] = '{kind: elt_pkg::KIND_END, start: sat16(pos_inc), len: 16'd0};
		end
	end

	// pack the valid tokens into the low slots, in order
	always_comb begin
		entry = '0;
		cnt   = '0;
		for (int i = 0; i < 4; i++) begin
			if (cv[i] && cnt != 2'd3) begin
				entry.tok[cnt] = cand[i];
				cnt = cnt + 2'd1;
			end
		end
		entry.cnt  = cnt;
		entry_push = accept && (cnt != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= elt_pkg::MODE_NONE;
			start_q <= '0;
			len_q   <= '0;
			pre_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (final_byte) begin
				mode_q  <= elt_pkg::MODE_NONE;
				start_q <= '0;
				len_q   <= '0;
				pre_q   <= '0;
				pos_q   <= '0;
			end else begin
				mode_q  <= mode_n;
				start_q <= start_n;
				len_q   <= len_n;
				pre_q   <= pre_n;
				pos_q   <= pos_inc;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/elt_queue.sv
// Short queue of token groups between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module elt_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  elt_pkg::entry_t      wr_data,
	output logic                 q_full,
	input  wire logic            rd,
	output elt_pkg::entry_t      rd_data,
	output logic                 q_empty
);

	elt_pkg::entry_t                    mem_q [elt_pkg::QUEUE_DEPTH];
	logic [elt_pkg::QUEUE_PTR_BITS-1:0] wp_q, rp_q;
	logic [elt_pkg::QUEUE_PTR_BITS:0]   count_q;

	assign q_full  = (count_q == (elt_pkg::QUEUE_PTR_BITS+1)'(elt_pkg::QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !wr) else $error("word written into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !rd) else $error("word read from empty queue");

endmodule

`default_nettype wire

// File: design/elt_back.sv
// Back end: serializes token groups into the output register.
`timescale 1ns / 1ps
`default_nettype none

module elt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  elt_pkg::entry_t     head,
	input  wire logic           q_empty,
	output logic                q_rd,
	input  wire logic           pop,
	output logic                empty,
	output logic [4:0]          token_kind,
	output logic [15:0]         start_offset,
	output logic [15:0]         token_length,
	output logic                run_last
);

	logic            valid_q;
	logic [1:0]      idx_q;
	logic            load, slot_last;
	elt_pkg::token_t tok_q;
	logic            last_q;

	assign load      = !q_empty && (!valid_q || pop);
	assign slot_last = (idx_q == head.cnt - 2'd1);
	assign q_rd      = load && slot_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (pop)
				valid_q <= 1'b0;
			if (load)
				idx_q <= slot_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head.tok[idx_q];
			last_q <= slot_last;
		end
	end

	assign empty        = !valid_q;
	assign token_kind   = tok_q.kind;
	assign start_offset = tok_q.start;
	assign token_length = tok_q.len;
	assign run_last     = last_q;

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < head.cnt)) else $error("slot index beyond group");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && tok_q.kind == elt_pkg::KIND_END) |-> last_q)
		else $error("end token not marked last");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the expression tokenizer: directed sources, random text, backpressure.
`timescale 1ns / 1ps

module testbench;

	localparam int POS_BITS = 16;
	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam logic [7:0] CH_0 = "0";
	localparam logic [7:0] CH_9 = "9";
	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_LZ = "z";
	localparam logic [7:0] CH_UA = "A";
	localparam logic [7:0] CH_UZ = "Z";
	// punctuation in token code order, plus at the low byte
	localparam logic [95:0] PUNCT_SET = {elt_pkg::CH_SEMI, elt_pkg::CH_COMMA,
		elt_pkg::CH_ASSIGN, elt_pkg::CH_RBRACE, elt_pkg::CH_LBRACE,
		elt_pkg::CH_RPAREN, elt_pkg::CH_LPAREN, elt_pkg::CH_CARET,
		elt_pkg::CH_SLASH, elt_pkg::CH_STAR, elt_pkg::CH_MINUS, elt_pkg::CH_PLUS};

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} token_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  source_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic [4:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic        run_last;
	logic        empty;

	token_exp_t expected_tokens[$];
	token_exp_t burst[3];
	int         burst_n;
	logic [7:0] fragment_bytes[$];

	elt_pkg::run_mode_t tok_mode = elt_pkg::MODE_NONE;
	logic [15:0] tok_start = '0;
	logic [15:0] tok_len = '0;
	logic [15:0] tok_pos = '0;
	logic [47:0] tok_prefix = '0;

	int errors = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off = 0;

	expression_language_tokenizer_core #(.POS_BITS(POS_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.source_byte(source_byte),
		.final_byte(final_byte),
		.push(push),
		.full(full),
		.token_kind(token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.run_last(run_last),
		.empty(empty),
		.pop(pop)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// ---------------- token predictor ----------------

	task automatic emit(input logic [4:0] k, input logic [15:0] s, input logic [15:0] l);
		burst[burst_n] = '{kind: k, start: s, len: l, last: 1'b0};
		burst_n++;
	endtask

	task automatic extend_run(input logic [7:0] c);
		if (tok_len < 16'd6)
			tok_prefix = {tok_prefix[39:0], c};
		if (tok_len != elt_pkg::LEN_MAX)
			tok_len++;
	endtask

	task automatic close_open_run();
		logic [4:0] k;
		k = elt_pkg::KIND_NUMBER;
		if (tok_mode == elt_pkg::MODE_IDENT) begin
			k = elt_pkg::KIND_IDENT;
			if (tok_len == 16'd3 && tok_prefix == elt_pkg::KW_VAR)
				k = elt_pkg::KIND_VAR;
			else if (tok_len == 16'd6 && tok_prefix == elt_pkg::KW_RETURN)
				k = elt_pkg::KIND_RETURN;
			else if (tok_len == 16'd3 && tok_prefix == elt_pkg::KW_FUN)
				k = elt_pkg::KIND_FUN;
		end
		emit(k, tok_start, tok_len);
		tok_mode = elt_pkg::MODE_NONE;
		tok_start = '0;
		tok_len = '0;
		tok_prefix = '0;
	endtask

	task automatic tokenize_byte(input logic [7:0] c, input logic fin);
		logic [15:0] here;
		logic        is_dig;
		logic        is_let;
		logic [4:0]  k;
		int          i;
		here = tok_pos;
		burst_n = 0;
		is_dig = c >= CH_0 && c <= CH_9;
		is_let = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
		if (tok_pos != POS_MAX)
			tok_pos++;
		if (tok_mode == elt_pkg::MODE_NUM && is_dig) begin
			extend_run(c);
		end else if (tok_mode == elt_pkg::MODE_IDENT && (is_let || is_dig)) begin
			extend_run(c);
		end else begin
			if (tok_mode != elt_pkg::MODE_NONE)
				close_open_run();
			if (is_dig || is_let) begin
				if (is_dig)
					tok_mode = elt_pkg::MODE_NUM;
				else
					tok_mode = elt_pkg::MODE_IDENT;
				tok_start = here;
				tok_len = '0;
				tok_prefix = '0;
				extend_run(c);
			end else if (c != elt_pkg::CH_SPACE && c != elt_pkg::CH_NEWLINE) begin
				k = elt_pkg::KIND_UNKNOWN;
				for (i = 0; i < 12; i++)
					if (PUNCT_SET[i*8 +: 8] == c)
						k = elt_pkg::KIND_PLUS + i[4:0];
				emit(k, here, 16'd1);
			end
		end
		if (fin) begin
			if (tok_mode != elt_pkg::MODE_NONE)
				close_open_run();
			emit(elt_pkg::KIND_END, tok_pos, 16'd0);
			tok_pos = '0;
		end
		for (i = 0; i < burst_n; i++) begin
			burst[i].last = (i == burst_n - 1);
			expected_tokens.push_back(burst[i]);
		end
	endtask

	// ---------------- result side ----------------

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_token();
		token_exp_t want;
		if (expected_tokens.size() == 0) begin
			errors++;
			$display("%0t: unexpected word, expected none actual kind %0d start %0d %s %0d %s %0d",
				$time, token_kind, start_offset, "length", token_length, "last", run_last);
		end else begin
			want = expected_tokens.pop_front();
			compare_field("token_kind", want.kind, token_kind);
			compare_field("start_offset", want.start, start_offset);
			compare_field("token_length", want.len, token_length);
			compare_field("run_last", want.last, run_last);
		end
	endtask

	always @(posedge clk) begin
		if (pop && !empty)
			check_token();
		if (hold_off > 0) begin
			hold_off = hold_off - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------- source side ----------------

	task automatic send_byte(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		source_byte <= c;
		final_byte <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tokenize_byte(c, fin);
	endtask

	task automatic send_text(input string s, input logic fin);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], fin && i == s.len() - 1);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	function automatic logic [7:0] random_letter();
		int r;
		r = $urandom_range(51);
		if (r < 26)
			return CH_LA + r[7:0];
		return CH_UA + r[7:0] - 8'd26;
	endfunction

	function automatic logic [7:0] random_digit();
		int r;
		r = $urandom_range(9);
		return CH_0 + r[7:0];
	endfunction

	function automatic logic [7:0] random_punct();
		int r;
		r = $urandom_range(11);
		return PUNCT_SET[r*8 +: 8];
	endfunction

	// one lexical fragment of mostly well-formed text
	task automatic make_fragment();
		int    pick;
		int    n;
		int    i;
		string kw;
		fragment_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 14) begin
			case ($urandom_range(2))
				0: kw = "var";
				1: kw = "return";
				default: kw = "fun";
			endcase
			for (i = 0; i < kw.len(); i++)
				fragment_bytes.push_back(kw[i]);
			if ($urandom_range(4) == 0)
				void'(fragment_bytes.pop_back());
			else if ($urandom_range(4) == 0)
				fragment_bytes.push_back(random_letter());
		end else if (pick < 32) begin
			fragment_bytes.push_back(random_letter());
			n = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(4);
			for (i = 0; i < n; i++)
				fragment_bytes.push_back(($urandom_range(3) == 0) ? random_digit() : random_letter());
		end else if (pick < 46) begin
			n = $urandom_range(1, 5);
			for (i = 0; i < n; i++)
				fragment_bytes.push_back(random_digit());
		end else if (pick < 70) begin
			fragment_bytes.push_back(random_punct());
		end else if (pick < 88) begin
			fragment_bytes.push_back(($urandom_range(1) == 0) ? elt_pkg::CH_SPACE :
				elt_pkg::CH_NEWLINE);
		end else begin
			fragment_bytes.push_back(8'($urandom_range(255)));
		end
		if (pick < 46 && $urandom_range(9) < 7)
			fragment_bytes.push_back(($urandom_range(1) == 0) ? elt_pkg::CH_SPACE :
				random_punct());
	endtask

	// ---------------- tests ----------------

	task automatic test_keywords_and_punct();
		send_text("var=fun,return;", 1'b1);
		send_text("(9a)^{b}+-*/", 1'b1);
		wait_drain();
	endtask

	task automatic test_edge_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(elt_pkg::CH_NEWLINE, 1'b0);
		send_text("returns", 1'b0);
		send_byte(elt_pkg::CH_SPACE, 1'b1);
		send_byte(elt_pkg::CH_SPACE, 1'b1);
		send_byte(elt_pkg::CH_NEWLINE, 1'b1);
		send_text("q;", 1'b1);
		wait_drain();
	endtask

	task automatic test_backpressure();
		int i;
		set_idling(0, 0);
		hold_off = 300;
		for (i = 0; i < 30; i++) begin
			send_byte(random_letter(), 1'b0);
			send_byte(random_punct(), i % 3 == 0);
		end
		wait_drain();
	endtask

	task automatic test_random_text(input int n_items);
		int sent;
		int i;
		sent = 0;
		while (sent < n_items) begin
			make_fragment();
			for (i = 0; i < fragment_bytes.size(); i++) begin
				send_byte(fragment_bytes[i], $urandom_range(99) < 4);
				sent++;
			end
		end
		send_byte(elt_pkg::CH_SPACE, 1'b1);
		wait_drain();
	endtask

	// identifier well past the keyword prefix, closed by punctuation, then a final digit
	task automatic test_long_source();
		int i;
		set_idling(0, 0);
		send_byte(random_letter(), 1'b0);
		for (i = 1; i < 40; i++)
			send_byte(($urandom_range(3) == 0) ? random_digit() : random_letter(), 1'b0);
		send_byte(elt_pkg::CH_PLUS, 1'b0);
		send_byte(CH_9, 1'b1);
		wait_drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(36, 64);
		test_keywords_and_punct();
		test_edge_bytes();
		test_backpressure();
		set_idling(36, 64);
		test_random_text(100);
		set_idling(64, 36);
		test_random_text(100);
		set_idling(0, 0);
		test_random_text(100);
		test_long_source();

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
